/* rtl/bmfe_pkg.sv */
// shared types, codes and the crc-16/modbus byte update for the bus master frame engine
`default_nettype none
package bmfe_pkg;

  // action codes on the input tuser
  localparam logic [2:0] ACT_HEADER  = 3'd0;
  localparam logic [2:0] ACT_PAYLOAD = 3'd1;
  localparam logic [2:0] ACT_RX_BYTE = 3'd2;
  localparam logic [2:0] ACT_TICK    = 3'd3;
  localparam logic [2:0] ACT_EDGE    = 3'd4;

  // result kinds on the output tuser
  localparam logic [2:0] KIND_XMIT    = 3'd0;
  localparam logic [2:0] KIND_RBYTE   = 3'd1;
  localparam logic [2:0] KIND_GOOD    = 3'd2;
  localparam logic [2:0] KIND_BAD_CRC = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;
  localparam logic [2:0] KIND_BC_ACK  = 3'd5;
  localparam logic [2:0] KIND_REJECT  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_IDX_SEED    = 2'd0;
  localparam logic [1:0] CFG_IDX_WINDOW  = 2'd1;
  localparam logic [1:0] CFG_IDX_TIMEOUT = 2'd2;

  localparam logic [15:0] CRC_SEED_RST = 16'd0;
  localparam logic [7:0]  WINDOW_RST   = 8'd5;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_HEADER,
    OP_PAYLOAD,
    OP_RX_BYTE,
    OP_TICK,
    OP_EDGE
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SENDING,
    PH_TX_DONE,
    PH_WAIT,
    PH_RECEIVING
  } phase_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_HDR_LEN,
    BS_HDR_CMD,
    BS_CRC_LO,
    BS_CRC_HI
  } bstate_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [8:0] len_word;
    logic [7:0] byte_value;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [8:0] word;
    logic [7:0] index;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [15:0] crc_seed;
    logic [7:0]  response_window_ticks;
    logic [15:0] receive_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_stat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/bmfe_front.sv */
// front end: accepts input items and classifies them into queue commands
`default_nettype none
module bmfe_front (
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [31:0]   s_tdata,  // address, command, payload_length, byte_value
  input  wire logic [2:0]    s_tuser,  // action
  input  wire logic          q_full,
  output logic               q_push,
  output bmfe_pkg::cmd_t     q_cmd
);
  import bmfe_pkg::*;

  op_t op;

  always_comb begin
    case (s_tuser)
      ACT_HEADER:  op = OP_HEADER;
      ACT_PAYLOAD: op = OP_PAYLOAD;
      ACT_RX_BYTE: op = OP_RX_BYTE;
      ACT_TICK:    op = OP_TICK;
      ACT_EDGE:    op = OP_EDGE;
      default:     op = OP_NONE;
    endcase
  end

  always_comb begin
    q_cmd.op             = op;
    q_cmd.address        = s_tdata[7:0];
    q_cmd.command        = s_tdata[15:8];
    q_cmd.payload_length = s_tdata[23:16];
    q_cmd.len_word       = {1'b0, s_tdata[23:16]} + 9'd1;
    q_cmd.byte_value     = s_tdata[31:24];
  end

  // unknown actions are taken and dropped here
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full && (op != OP_NONE);

endmodule
`default_nettype wire

/* rtl/bmfe_queue.sv */
// small command queue between front and back
`default_nettype none
module bmfe_queue #(
  parameter int DEPTH = bmfe_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bmfe_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output logic                full,
  output logic                valid,
  output bmfe_pkg::cmd_t      head
);
  import bmfe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == DEPTH_CNT);
  assign valid   = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/bmfe_back.sv */
// back end: transaction state, frame sequencer, crc and the output register
`default_nettype none
module bmfe_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bmfe_pkg::cfg_t cfg,
  input  wire logic           q_valid,
  input  wire bmfe_pkg::cmd_t q_cmd,
  output bmfe_pkg::back_stat_t stat,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output bmfe_pkg::res_t      m_res
);
  import bmfe_pkg::*;

  bstate_t     bstate, bstate_next;
  phase_t      phase, phase_next;
  logic [15:0] tx_crc, tx_crc_next;
  logic [7:0]  payload_left, payload_left_next;
  logic [7:0]  dest_address, dest_address_next;
  logic [7:0]  response_ticks, response_ticks_next;
  logic [15:0] receive_ticks, receive_ticks_next;
  logic [7:0]  reply_length, reply_length_next;
  logic [8:0]  reply_count, reply_count_next;
  logic [15:0] rx_crc, rx_crc_next;
  logic [7:0]  crc_low_seen, crc_low_seen_next;
  logic [8:0]  len_word, len_word_next;
  logic [7:0]  cmd_byte, cmd_byte_next;

  logic        slot_free;
  logic        go;
  logic        emit;
  res_t        res;

  logic        rx_wait;
  logic [8:0]  rc;
  logic [7:0]  rlen;
  logic [15:0] crc_in;
  logic [7:0]  low_in;
  logic [15:0] rx_step;
  logic [7:0]  window_eff;
  logic [15:0] timeout_eff;
  logic [7:0]  tx_byte;
  logic [15:0] tx_step;

  assign slot_free = !m_tvalid || m_tready;
  assign go        = slot_free && ((bstate != BS_IDLE) || q_valid);
  assign stat.pop  = go && (bstate == BS_IDLE);
  assign stat.busy = (bstate != BS_IDLE);

  assign window_eff  = (cfg.response_window_ticks == '0) ? 8'd1 : cfg.response_window_ticks;
  assign timeout_eff = (cfg.receive_timeout_ticks == '0) ? 16'd1 : cfg.receive_timeout_ticks;

  // reception start folded in for a byte arriving inside the window
  assign rx_wait = (phase == PH_WAIT);
  assign rc      = rx_wait ? 9'd0 : reply_count;
  assign rlen    = rx_wait ? 8'd0 : reply_length;
  assign crc_in  = rx_wait ? cfg.crc_seed : rx_crc;
  assign low_in  = rx_wait ? 8'd0 : crc_low_seen;
  assign rx_step = crc16_byte(crc_in, q_cmd.byte_value);

  // one crc byte step per cycle on the transmit side, while the output slot is free
  always_comb begin
    case (bstate)
      BS_HDR_LEN: tx_byte = len_word[7:0];
      BS_HDR_CMD: tx_byte = cmd_byte;
      default:    tx_byte = q_cmd.byte_value;
    endcase
  end
  assign tx_step = crc16_byte(tx_crc, tx_byte);

  always_comb begin
    bstate_next = bstate;
    case (bstate)
      BS_IDLE: begin
        if (go && q_cmd.op == OP_HEADER && phase == PH_IDLE) begin
          bstate_next = BS_HDR_LEN;
        end else if (go && q_cmd.op == OP_PAYLOAD && phase == PH_SENDING &&
                     payload_left == 8'd1) begin
          bstate_next = BS_CRC_LO;
        end
      end
      BS_HDR_LEN: begin
        if (go) bstate_next = BS_HDR_CMD;
      end
      BS_HDR_CMD: begin
        if (go) bstate_next = (payload_left == '0) ? BS_CRC_LO : BS_IDLE;
      end
      BS_CRC_LO: begin
        if (go) bstate_next = BS_CRC_HI;
      end
      BS_CRC_HI: begin
        if (go) bstate_next = BS_IDLE;
      end
      default: bstate_next = BS_IDLE;
    endcase
  end

  always_comb begin
    phase_next          = phase;
    tx_crc_next         = tx_crc;
    payload_left_next   = payload_left;
    dest_address_next   = dest_address;
    response_ticks_next = response_ticks;
    receive_ticks_next  = receive_ticks;
    reply_length_next   = reply_length;
    reply_count_next    = reply_count;
    rx_crc_next         = rx_crc;
    crc_low_seen_next   = crc_low_seen;
    len_word_next       = len_word;
    cmd_byte_next       = cmd_byte;
    emit                = 1'b0;
    res.kind            = KIND_XMIT;
    res.word            = '0;
    res.index           = '0;
    res.last            = 1'b1;

    if (go) begin
      case (bstate)
        BS_IDLE: begin
          case (q_cmd.op)
            OP_HEADER: begin
              emit = 1'b1;
              if (phase != PH_IDLE) begin
                res.kind = KIND_REJECT;
              end else begin
                dest_address_next = q_cmd.address;
                payload_left_next = q_cmd.payload_length;
                tx_crc_next       = crc16_byte(cfg.crc_seed, q_cmd.address);
                len_word_next     = q_cmd.len_word;
                cmd_byte_next     = q_cmd.command;
                phase_next        = PH_SENDING;
                res.word          = {1'b1, q_cmd.address};
                res.last          = 1'b0;
              end
            end
            OP_PAYLOAD: begin
              if (phase == PH_SENDING && payload_left != '0) begin
                emit              = 1'b1;
                res.word          = {1'b0, q_cmd.byte_value};
                tx_crc_next       = tx_step;
                payload_left_next = payload_left - 8'd1;
                if (payload_left == 8'd1) begin
                  phase_next = PH_TX_DONE;
                  res.last   = 1'b0;
                end
              end
            end
            OP_RX_BYTE: begin
              if (rx_wait || phase == PH_RECEIVING) begin
                if (rx_wait) begin
                  response_ticks_next = '0;
                  receive_ticks_next  = timeout_eff;
                  reply_count_next    = '0;
                  reply_length_next   = '0;
                  crc_low_seen_next   = '0;
                  rx_crc_next         = cfg.crc_seed;
                  phase_next          = PH_RECEIVING;
                end
                if (rc == '0) begin
                  reply_length_next = q_cmd.byte_value;
                  rx_crc_next       = rx_step;
                  emit              = 1'b1;
                  res.kind          = KIND_RBYTE;
                  res.word          = {1'b0, q_cmd.byte_value};
                  reply_count_next  = 9'd1;
                end else if (rc <= {1'b0, rlen}) begin
                  rx_crc_next      = rx_step;
                  emit             = 1'b1;
                  res.kind         = KIND_RBYTE;
                  res.word         = {1'b0, q_cmd.byte_value};
                  res.index        = rc[7:0];
                  reply_count_next = rc + 9'd1;
                end else if (rc == {1'b0, rlen} + 9'd1) begin
                  crc_low_seen_next = q_cmd.byte_value;
                  reply_count_next  = rc + 9'd1;
                end else begin
                  emit = 1'b1;
                  if (low_in == crc_in[7:0] && q_cmd.byte_value == crc_in[15:8]) begin
                    res.kind = KIND_GOOD;
                  end else begin
                    res.kind = KIND_BAD_CRC;
                  end
                  reply_count_next   = '0;
                  receive_ticks_next = '0;
                  phase_next         = PH_IDLE;
                end
              end
            end
            OP_TICK: begin
              case (phase)
                PH_TX_DONE: begin
                  if (dest_address == '0) begin
                    emit       = 1'b1;
                    res.kind   = KIND_BC_ACK;
                    phase_next = PH_IDLE;
                  end else begin
                    response_ticks_next = window_eff;
                    phase_next          = PH_WAIT;
                  end
                end
                PH_WAIT: begin
                  if (response_ticks <= 8'd1) begin
                    response_ticks_next = '0;
                    emit                = 1'b1;
                    res.kind            = KIND_TIMEOUT;
                    phase_next          = PH_IDLE;
                  end else begin
                    response_ticks_next = response_ticks - 8'd1;
                  end
                end
                PH_RECEIVING: begin
                  if (receive_ticks <= 16'd1) begin
                    receive_ticks_next = '0;
                    reply_count_next   = '0;
                    emit               = 1'b1;
                    res.kind           = KIND_TIMEOUT;
                    phase_next         = PH_IDLE;
                  end else begin
                    receive_ticks_next = receive_ticks - 16'd1;
                  end
                end
                default: ;
              endcase
            end
            OP_EDGE: begin
              if (rx_wait) begin
                response_ticks_next = '0;
                receive_ticks_next  = timeout_eff;
                reply_count_next    = '0;
                reply_length_next   = '0;
                crc_low_seen_next   = '0;
                rx_crc_next         = cfg.crc_seed;
                phase_next          = PH_RECEIVING;
              end
            end
            default: ;
          endcase
        end
        BS_HDR_LEN: begin
          emit        = 1'b1;
          res.word    = len_word;
          res.last    = 1'b0;
          tx_crc_next = tx_step;
        end
        BS_HDR_CMD: begin
          emit        = 1'b1;
          res.word    = {1'b0, cmd_byte};
          res.last    = (payload_left != '0);
          tx_crc_next = tx_step;
          if (payload_left == '0) begin
            phase_next = PH_TX_DONE;
          end
        end
        BS_CRC_LO: begin
          emit     = 1'b1;
          res.word = {1'b0, tx_crc[7:0]};
          res.last = 1'b0;
        end
        BS_CRC_HI: begin
          emit     = 1'b1;
          res.word = {1'b0, tx_crc[15:8]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate         <= BS_IDLE;
      phase          <= PH_IDLE;
      tx_crc         <= '0;
      payload_left   <= '0;
      dest_address   <= '0;
      response_ticks <= '0;
      receive_ticks  <= '0;
      reply_length   <= '0;
      reply_count    <= '0;
      rx_crc         <= '0;
      crc_low_seen   <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      bstate         <= bstate_next;
      phase          <= phase_next;
      tx_crc         <= tx_crc_next;
      payload_left   <= payload_left_next;
      dest_address   <= dest_address_next;
      response_ticks <= response_ticks_next;
      receive_ticks  <= receive_ticks_next;
      reply_length   <= reply_length_next;
      reply_count    <= reply_count_next;
      rx_crc         <= rx_crc_next;
      crc_low_seen   <= crc_low_seen_next;
      if (slot_free) begin
        m_tvalid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_word <= len_word_next;
    cmd_byte <= cmd_byte_next;
    if (slot_free) begin
      m_res <= res;
    end
  end

endmodule
`default_nettype wire

/* rtl/bus_master_frame_engine_core.sv */
// top level of the 9-bit rs485 bus master frame engine
`default_nettype none
// Master side of a 9-bit RS485 bus with CRC-16/MODBUS framing. Input items are
// classified on arrival and held in a command queue of QUEUE_DEPTH entries; a back
// end sequencer executes them and drives one result item per cycle, while the sink
// is ready, through an output register. A header is sent as address, length word
// and command, then the two CRC bytes when it has no payload; a rejected header gives
// one reject item. The last payload byte is followed by the two CRC bytes, and the
// CRC is advanced one byte per cycle by the sequencer while the output is not stalled.
// The input side keeps accepting while the queue has room, so a slow sink only stalls
// the front once the queue fills. Configuration writes are registered and accepted every cycle.
module bus_master_frame_engine_core #(
  parameter int QUEUE_DEPTH = bmfe_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // address, command, payload_length, byte_value
  input  wire logic [2:0]  s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // word, index, zero fill
  output logic [2:0]       m_tuser,   // kind
  output logic             m_tlast,   // last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import bmfe_pkg::*;

  cfg_t       cfg;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       q_push;
  logic       q_full;
  logic       q_valid;
  back_stat_t stat;
  res_t       res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_seed              <= CRC_SEED_RST;
      cfg.response_window_ticks <= WINDOW_RST;
      cfg.receive_timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_SEED:    cfg.crc_seed              <= cfg_data;
        CFG_IDX_WINDOW:  cfg.response_window_ticks <= cfg_data[7:0];
        CFG_IDX_TIMEOUT: cfg.receive_timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  bmfe_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  bmfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (stat.pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  bmfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (res)
  );

  assign m_tdata = {7'd0, res.index, res.word};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

  // the back end only takes a queued item when one is there
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> q_valid)
    else $error("queue popped while empty");

  // no new item is taken while the sequencer is busy with header or crc bytes
  a_no_pop_mid_frame: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !stat.pop)
    else $error("item taken in the middle of a frame");

  // status results carry no word
  a_status_word_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_XMIT && m_tuser != KIND_RBYTE) |-> (m_tdata[8:0] == 9'd0))
    else $error("status item with nonzero word");

  // a rejected header is a single result item
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_REJECT) |-> m_tlast)
    else $error("reject item without last");

endmodule
`default_nettype wire
